// File: sv/lkvc_pkg.sv
// shared constants and types of the lru key/value cache
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    localparam int LKVC_ENTRY_COUNT = 8;
    localparam int LKVC_KEY_BITS    = 32;
    localparam int KEY_IN_W         = 32;
    localparam int PAYLOAD_W        = 64;

    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic en;
        logic is_get;
        logic kind;
    } cell_cmp_t;

endpackage

`default_nettype wire

// File: sv/lkvc_if.sv
// request and response channel interfaces of the lru key/value cache
`timescale 1ns / 1ps
`default_nettype none

interface lkvc_req_if
    import lkvc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [KEY_IN_W-1:0]  lookup_key;
    logic                 kind_in;
    logic [PAYLOAD_W-1:0] payload_in;

    modport source (output valid, output cmd, output lookup_key, output kind_in,
                    output payload_in, input ready);
    modport sink   (input valid, input cmd, input lookup_key, input kind_in,
                    input payload_in, output ready);
endinterface

interface lkvc_rsp_if
    import lkvc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [PAYLOAD_W-1:0] payload_out;

    modport source (output valid, output hit, output payload_out, input ready);
    modport sink   (input valid, input hit, input payload_out, output ready);
endinterface

`default_nettype wire

// File: sv/lkvc_cell.sv
// one cache slot: holds an entry, matches it against the request, takes its neighbour's entry
`timescale 1ns / 1ps
`default_nettype none

module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int KEY_BITS = LKVC_KEY_BITS
) (
    input  wire logic                 clk,
    input  wire cell_cmp_t            cmp,
    input  wire logic                 slot_valid,
    input  wire logic [KEY_BITS-1:0]  req_key,
    input  wire logic                 load,
    input  wire logic [KEY_BITS-1:0]  nb_key,
    input  wire logic                 nb_kind,
    input  wire logic [PAYLOAD_W-1:0] nb_payload,
    output logic [KEY_BITS-1:0]       key,
    output logic                      kind,
    output logic [PAYLOAD_W-1:0]      payload,
    output logic                      match
);

    logic [KEY_BITS-1:0]  key_reg;
    logic                 kind_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic                 match_reg;
    logic                 match_next;

    always_comb
    begin
        match_next = slot_valid && (key_reg == req_key) && (!cmp.is_get || kind_reg == cmp.kind);
    end

    always_ff @(posedge clk)
    begin
        if (cmp.en)
        begin
            match_reg <= match_next;
        end
        if (load)
        begin
            key_reg     <= nb_key;
            kind_reg    <= nb_kind;
            payload_reg <= nb_payload;
        end
    end

    assign key     = key_reg;
    assign kind    = kind_reg;
    assign payload = payload_reg;
    assign match   = match_reg;

endmodule

`default_nettype wire

// File: sv/lru_key_value_cache_top.sv
// top level of the fully associative lru key/value cache
`timescale 1ns / 1ps
`default_nettype none

// Fully associative key/value cache of ENTRY_COUNT slots kept in recency order, slot 0 the most
// recent. Each request beat passes through a compare cycle in which every slot cell matches its
// key (and, for a get, its type tag) against the request, and an update cycle in which the first
// matching slot, or for a put miss the new entry, moves to the front while the slots ahead of it
// step back by one along the row of cells. The next request beat is taken during the update cycle;
// a result beat that the sink has not taken holds the update cycle until the response register is
// free. No clearing pass is needed after reset.
module lru_key_value_cache_top
    import lkvc_pkg::*;
#(
    parameter int ENTRY_COUNT = LKVC_ENTRY_COUNT,
    parameter int KEY_BITS    = LKVC_KEY_BITS
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lkvc_req_if.sink    req,
    lkvc_rsp_if.source  rsp
);

    localparam int FILL_W = $clog2(ENTRY_COUNT + 1);

    state_t state_reg;
    state_t state_next;

    logic                 cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic                 kind_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_hit_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;

    logic                 accept;
    logic                 out_free;
    logic                 upd_go;
    logic                 hit_any;
    logic                 is_put;
    logic [PAYLOAD_W-1:0] sel_payload;
    logic [PAYLOAD_W-1:0] front_payload;

    cell_cmp_t            cmp;

    logic [ENTRY_COUNT-1:0] match;
    logic [ENTRY_COUNT-1:0] prior;
    logic [ENTRY_COUNT-1:0] first;
    logic [ENTRY_COUNT-1:0] load;
    logic [ENTRY_COUNT-1:0] slot_valid;

    logic [KEY_BITS-1:0]  ent_key     [ENTRY_COUNT];
    logic                 ent_kind    [ENTRY_COUNT];
    logic [PAYLOAD_W-1:0] ent_payload [ENTRY_COUNT];

    assign out_free = !out_valid_reg || rsp.ready;
    assign upd_go   = (state_reg == ST_UPD) && out_free;
    assign accept   = req.valid && req.ready;
    assign is_put   = (cmd_reg == CMD_PUT);

    always_comb
    begin
        req.ready  = (state_reg == ST_IDLE) || upd_go;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= req.cmd;
            key_reg     <= KEY_BITS'(req.lookup_key);
            kind_reg    <= req.kind_in;
            payload_reg <= req.payload_in;
        end
        if (upd_go)
        begin
            out_hit_reg     <= hit_any;
            out_payload_reg <= (!is_put && hit_any) ? sel_payload : '0;
        end
    end

    assign cmp.en     = (state_reg == ST_CMP);
    assign cmp.is_get = (cmd_reg == CMD_GET);
    assign cmp.kind   = kind_reg;

    assign hit_any = |match;

    always_comb
    begin
        sel_payload = '0;
        for (int i = 0; i < ENTRY_COUNT; i++)
        begin
            sel_payload = sel_payload | ({PAYLOAD_W{first[i]}} & ent_payload[i]);
        end
    end

    assign front_payload = is_put ? payload_reg : sel_payload;

    always_comb
    begin
        fill_next = fill_reg;
        if (upd_go && is_put && !hit_any && (fill_reg < FILL_W'(ENTRY_COUNT)))
        begin
            fill_next = fill_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (upd_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < ENTRY_COUNT; g++)
        begin : g_cell
            assign slot_valid[g] = (FILL_W'(g) < fill_reg);
            if (g == 0)
            begin : g_front
                assign prior[g] = 1'b0;
                assign load[g]  = upd_go && (hit_any || is_put);
            end
            else
            begin : g_rest
                assign prior[g] = |match[g-1:0];
                assign load[g]  = upd_go && (hit_any ? !prior[g]
                                                     : (is_put && (FILL_W'(g) <= fill_reg)));
            end
            assign first[g] = match[g] && !prior[g];

            lkvc_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .clk        (clk),
                .cmp        (cmp),
                .slot_valid (slot_valid[g]),
                .req_key    (key_reg),
                .load       (load[g]),
                .nb_key     ((g == 0) ? key_reg       : ent_key[(g == 0) ? 0 : g - 1]),
                .nb_kind    ((g == 0) ? kind_reg      : ent_kind[(g == 0) ? 0 : g - 1]),
                .nb_payload ((g == 0) ? front_payload : ent_payload[(g == 0) ? 0 : g - 1]),
                .key        (ent_key[g]),
                .kind       (ent_kind[g]),
                .payload    (ent_payload[g]),
                .match      (match[g])
            );
        end
    endgenerate

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.payload_out = out_payload_reg;

endmodule

`default_nettype wire

// File: sv/lkvc_checker.sv
// port-level assertions for the lru key/value cache, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic                 rsp_hit,
    input wire logic [PAYLOAD_W-1:0] rsp_payload_out
);

    // a waiting result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped before it was taken");

    // a miss never carries a payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_payload_out == '0)
        else $error("payload on a miss");

    // compare cycle follows every request beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken during compare cycle");

    // a result is on offer shortly after each request beat
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##3 rsp_valid)
        else $error("no result after request beat");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_hit         (rsp.hit),
    .rsp_payload_out (rsp.payload_out)
);

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench of the lru key/value cache: recency-order predictor and random traffic
`timescale 1ns / 1ps

class cache_scoreboard;

    typedef struct packed {
        logic                 hit;
        logic [lkvc_pkg::PAYLOAD_W-1:0] payload;
    } cache_result_t;

    logic [lkvc_pkg::KEY_IN_W-1:0]  key_slot[lkvc_pkg::LKVC_ENTRY_COUNT];
    logic [lkvc_pkg::PAYLOAD_W-1:0] payload_slot[lkvc_pkg::LKVC_ENTRY_COUNT];
    logic                           kind_slot[lkvc_pkg::LKVC_ENTRY_COUNT];
    int                             fill;
    cache_result_t                  expected_q[$];
    int                             mismatches;

    function void clear();
        fill = 0;
        mismatches = 0;
        expected_q.delete();
    endfunction

    function logic [lkvc_pkg::KEY_IN_W-1:0] kept_key(logic [lkvc_pkg::KEY_IN_W-1:0] raw);
        logic [lkvc_pkg::KEY_IN_W-1:0] mask;
        logic [63:0]                   wide_mask;
        wide_mask = (64'd1 << lkvc_pkg::LKVC_KEY_BITS) - 64'd1;
        if (lkvc_pkg::LKVC_KEY_BITS >= lkvc_pkg::KEY_IN_W)
            mask = '1;
        else
            mask = wide_mask[lkvc_pkg::KEY_IN_W-1:0];
        return raw & mask;
    endfunction

    // slots ahead of pos step back by one, the entry lands in slot 0
    function void move_to_front(int pos, logic [lkvc_pkg::KEY_IN_W-1:0] key,
                                logic [lkvc_pkg::PAYLOAD_W-1:0] payload, logic kind);
        for (int i = pos; i > 0; i--)
        begin
            key_slot[i]     = key_slot[i-1];
            payload_slot[i] = payload_slot[i-1];
            kind_slot[i]    = kind_slot[i-1];
        end
        key_slot[0]     = key;
        payload_slot[0] = payload;
        kind_slot[0]    = kind;
    endfunction

    function void note_request(logic cmd, logic [lkvc_pkg::KEY_IN_W-1:0] lookup_key,
                               logic kind, logic [lkvc_pkg::PAYLOAD_W-1:0] payload);
        logic [lkvc_pkg::KEY_IN_W-1:0] key;
        cache_result_t                 res;
        int                            found;
        key   = kept_key(lookup_key);
        res   = '0;
        found = -1;
        if (cmd == lkvc_pkg::CMD_PUT)
        begin
            for (int i = 0; i < fill; i++)
                if (found < 0 && key_slot[i] == key)
                    found = i;
            if (found >= 0)
            begin
                res.hit = 1'b1;
                move_to_front(found, key, payload, kind);
            end
            else if (fill < lkvc_pkg::LKVC_ENTRY_COUNT)
            begin
                move_to_front(fill, key, payload, kind);
                fill++;
            end
            else
                move_to_front(lkvc_pkg::LKVC_ENTRY_COUNT - 1, key, payload, kind);
        end
        else
        begin
            for (int i = 0; i < fill; i++)
                if (found < 0 && key_slot[i] == key && kind_slot[i] == kind)
                    found = i;
            if (found >= 0)
            begin
                res.hit     = 1'b1;
                res.payload = payload_slot[found];
                move_to_front(found, key, payload_slot[found], kind);
            end
        end
        expected_q.push_back(res);
    endfunction

    function void check_result(logic hit, logic [lkvc_pkg::PAYLOAD_W-1:0] payload);
        cache_result_t exp_res;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: hit=%0b payload=%h", hit, payload);
            return;
        end
        exp_res = expected_q.pop_front();
        if (hit !== exp_res.hit || payload !== exp_res.payload)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected hit=%0b payload=%h, got hit=%0b payload=%h",
                         exp_res.hit, exp_res.payload, hit, payload);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

endclass

module testbench;
    import lkvc_pkg::*;

    localparam logic KIND_INT    = 1'b0;
    localparam logic KIND_DOUBLE = 1'b1;
    localparam int   POOL_SIZE   = 12;
    localparam int   IDLE_LIMIT  = 3000;
    localparam int   HOLD_CYCLES = 400;

    logic clk;
    logic rst_n;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    cache_scoreboard    sb;
    int                 burst_left;
    int                 idle_cycles;
    bit                 hold_off_wanted;
    bit                 hold_off_done;
    logic [KEY_IN_W-1:0] key_pool[POOL_SIZE];
    logic               pool_kind[POOL_SIZE];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // note requests before results so a same-edge result still pops the oldest
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.cmd, req_ch.lookup_key, req_ch.kind_in, req_ch.payload_in);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.hit, rsp_ch.payload_out);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_request(logic cmd, logic [KEY_IN_W-1:0] key, logic kind,
                                logic [PAYLOAD_W-1:0] payload);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.lookup_key <= key;
        req_ch.kind_in    <= kind;
        req_ch.payload_in <= payload;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        burst_left--;
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i]  = $urandom;
            pool_kind[i] = 1'($urandom_range(0, 1));
        end
    endtask

    // response side: stretches of steady, random and sparse acceptance, and one long hold-off
    initial
    begin
        int mode;
        int span;
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_wanted && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    rsp_ch.ready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
                for (int c = 0; c < span; c++)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                        2:       rsp_ch.ready <= ($urandom_range(0, 4) != 0);
                        default: rsp_ch.ready <= (c % 3 == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin
        logic [KEY_IN_W-1:0]  key;
        logic [PAYLOAD_W-1:0] payload;
        logic                 cmd;
        logic                 kind;
        int                   idx;
        sb = new;
        sb.clear();
        burst_left      = 0;
        hold_off_wanted = 1'b0;
        hold_off_done   = 1'b0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_PUT;
        req_ch.lookup_key <= '0;
        req_ch.kind_in    <= KIND_INT;
        req_ch.payload_in <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, extremes, tag mismatch, retag on put, eviction order
        send_request(CMD_GET, 32'h0000_0000, KIND_INT, '0);
        send_request(CMD_PUT, 32'h0000_0000, KIND_INT, 64'h0);
        send_request(CMD_PUT, 32'hFFFF_FFFF, KIND_DOUBLE, '1);
        send_request(CMD_GET, 32'hFFFF_FFFF, KIND_DOUBLE, '0);
        send_request(CMD_GET, 32'h0000_0000, KIND_DOUBLE, '0);
        send_request(CMD_GET, 32'h0000_0000, KIND_INT, '0);
        send_request(CMD_PUT, 32'h0000_0000, KIND_DOUBLE, 64'hA5A5_5A5A_0F0F_F0F0);
        send_request(CMD_GET, 32'h0000_0000, KIND_INT, '0);
        send_request(CMD_GET, 32'h0000_0000, KIND_DOUBLE, '1);
        for (int i = 1; i <= 7; i++)
            send_request(CMD_PUT, i, KIND_INT, {$urandom, $urandom});
        send_request(CMD_GET, 32'hFFFF_FFFF, KIND_DOUBLE, '0);
        send_request(CMD_GET, 32'h0000_0001, KIND_INT, '0);
        send_request(CMD_PUT, 32'h0000_0008, KIND_DOUBLE, {$urandom, $urandom});
        send_request(CMD_GET, 32'h0000_0001, KIND_INT, '0);
        send_request(CMD_GET, 32'h0000_0000, KIND_DOUBLE, '0);

        // mostly keys from a small pool so hits, retags and evictions keep coming
        for (int n = 0; n < 1000; n++)
        begin
            if (n % 250 == 0)
                refresh_pool();
            if (n == 300)
                hold_off_wanted = 1'b1;
            if ($urandom_range(0, 99) < 85)
            begin
                idx  = $urandom_range(0, POOL_SIZE - 1);
                key  = key_pool[idx];
                kind = ($urandom_range(0, 4) == 0) ? ~pool_kind[idx] : pool_kind[idx];
            end
            else
            begin
                key  = $urandom;
                kind = 1'($urandom_range(0, 1));
            end
            cmd     = $urandom_range(0, 1) ? CMD_GET : CMD_PUT;
            payload = {$urandom, $urandom};
            send_request(cmd, key, kind, payload);
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
sv/lkvc_pkg.sv
sv/lkvc_if.sv
sv/lkvc_cell.sv
sv/lru_key_value_cache_top.sv
sv/lkvc_checker.sv
verif/testbench.sv
